// ===== rtl/mec_pkg.sv =====
// Package: shared types, constants and the trio check for the Mendelian error checker.
package mec_pkg;

    localparam int DEF_NUM_LOCI = 1024;
    localparam int LOCUS_W      = 10;
    localparam int LOCUS_EXT_W  = 17;
    localparam int GT_W         = 2;
    localparam int TALLY11_W    = 11;
    localparam int TALLY16_W    = 16;
    localparam int TALLY32_W    = 32;
    localparam int CLEAN_W      = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [GT_W-1:0] GT_MISSING = 2'd0;
    localparam logic [GT_W-1:0] GT_HET     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PURGE_THR   = 1'd1;

    localparam logic [CLEAN_W-1:0] CLEAN_RESET = 2'd1;
    localparam logic [CLEAN_W-1:0] CLEAN_STRIP = 2'd1;
    localparam logic [CLEAN_W-1:0] CLEAN_PURGE = 2'd3;

    typedef struct packed {
        logic [LOCUS_W-1:0] locus;
        logic [GT_W-1:0]    mother_gt;
        logic [GT_W-1:0]    father_gt;
        logic [GT_W-1:0]    child_gt;
        logic               has_parents;
        logic               last_of_individual;
        logic               last_of_pedigree;
        logic               first_of_report;
    } t_item;

    typedef struct packed {
        logic                 mismatch;
        logic [TALLY16_W-1:0] locus_flag_count;
        logic                 individual_done;
        logic [TALLY11_W-1:0] individual_errors;
        logic [TALLY11_W-1:0] missing_parent_count;
        logic [TALLY11_W-1:0] missing_child_count;
        logic                 pedigree_done;
        logic [TALLY16_W-1:0] pedigree_errors;
        logic [TALLY11_W-1:0] problem_loci_count;
        logic                 strip_loci;
        logic                 purge_pedigree;
        logic [TALLY32_W-1:0] report_errors;
    } t_result;

    typedef struct packed {
        logic load_item;
        logic sweep_bmp;
        logic sweep_cnt;
        logic idx_inc;
        logic chk_rd;
        logic update;
        logic walk_rd;
        logic look_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic walk_req;
        logic out_free;
    } t_dp_sts;

    function automatic logic trio_consistent(input logic [GT_W-1:0] m,
                                             input logic [GT_W-1:0] f,
                                             input logic [GT_W-1:0] t);
        logic [GT_W-1:0] diff;
        diff = (m > f) ? (m - f) : (f - m);
        if (m == f) begin
            trio_consistent = (m == GT_HET) || (t == m);
        end else if (diff == 2'd1) begin
            trio_consistent = (t == m) || (t == f);
        end else begin
            trio_consistent = (t == GT_HET);
        end
    endfunction

endpackage

// ===== rtl/mec_ifs.sv =====
// Interfaces: genotype request channel, result channel and register write channel.
interface mec_item_if;
    logic                          valid;
    logic                          ready;
    logic [mec_pkg::LOCUS_W-1:0]   locus;
    logic [mec_pkg::GT_W-1:0]      mother_gt;
    logic [mec_pkg::GT_W-1:0]      father_gt;
    logic [mec_pkg::GT_W-1:0]      child_gt;
    logic                          has_parents;
    logic                          last_of_individual;
    logic                          last_of_pedigree;
    logic                          first_of_report;

    modport source (output valid, locus, mother_gt, father_gt, child_gt, has_parents,
                    last_of_individual, last_of_pedigree, first_of_report,
                    input ready);
    modport sink (input valid, locus, mother_gt, father_gt, child_gt, has_parents,
                  last_of_individual, last_of_pedigree, first_of_report,
                  output ready);
endinterface

interface mec_result_if;
    logic                            valid;
    logic                            ready;
    logic                            mismatch;
    logic [mec_pkg::TALLY16_W-1:0]   locus_flag_count;
    logic                            individual_done;
    logic [mec_pkg::TALLY11_W-1:0]   individual_errors;
    logic [mec_pkg::TALLY11_W-1:0]   missing_parent_count;
    logic [mec_pkg::TALLY11_W-1:0]   missing_child_count;
    logic                            pedigree_done;
    logic [mec_pkg::TALLY16_W-1:0]   pedigree_errors;
    logic [mec_pkg::TALLY11_W-1:0]   problem_loci_count;
    logic                            strip_loci;
    logic                            purge_pedigree;
    logic [mec_pkg::TALLY32_W-1:0]   report_errors;

    modport source (output valid, mismatch, locus_flag_count, individual_done,
                    individual_errors, missing_parent_count, missing_child_count,
                    pedigree_done, pedigree_errors, problem_loci_count, strip_loci,
                    purge_pedigree, report_errors,
                    input ready);
    modport sink (input valid, mismatch, locus_flag_count, individual_done,
                  individual_errors, missing_parent_count, missing_child_count,
                  pedigree_done, pedigree_errors, problem_loci_count, strip_loci,
                  purge_pedigree, report_errors,
                  output ready);
endinterface

interface mec_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mec_pkg::CFG_IDX_W-1:0]    index;
    logic [mec_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mec_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/mec_ctrl.sv =====
// Controller: sequences memory clears, trio check, bitmap walk and result hand-off.
module mec_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_first,
    output logic             o_in_ready,
    input  mec_pkg::t_dp_sts i_sts,
    output mec_pkg::t_dp_cmd o_cmd
);
    import mec_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR_CNT,
        S_CHECK,
        S_UPDATE,
        S_WALK,
        S_WALK_END,
        S_LOOKUP,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_bmp = 1'b1;
                o_cmd.sweep_cnt = 1'b1;
                o_cmd.idx_inc   = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = i_in_first ? S_CLR_CNT : S_CHECK;
                end
            end
            S_CLR_CNT: begin
                o_cmd.sweep_cnt = 1'b1;
                o_cmd.idx_inc   = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.chk_rd = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = i_sts.walk_req ? S_WALK : S_LOOKUP;
            end
            S_WALK: begin
                o_cmd.walk_rd = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_WALK_END;
                end
            end
            S_WALK_END: begin
                n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.look_rd = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

// ===== rtl/mec_dp.sv =====
// Datapath: tallies, registers, problem bitmap and locus counter memories, result register.
module mec_dp #(
    parameter int NUM_LOCI = mec_pkg::DEF_NUM_LOCI
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mec_pkg::t_dp_cmd                i_cmd,
    output mec_pkg::t_dp_sts                o_sts,
    input  mec_pkg::t_item                  i_item,
    input  logic                            i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output mec_pkg::t_result                o_result
);
    import mec_pkg::*;

    localparam int ADDR_W = (NUM_LOCI > 1) ? $clog2(NUM_LOCI) : 1;
    localparam logic [ADDR_W-1:0]      IDX_LAST  = ADDR_W'(NUM_LOCI - 1);
    localparam logic [LOCUS_EXT_W-1:0] LOCI_EXT  = LOCUS_EXT_W'(NUM_LOCI);

    t_item                 r_item;
    logic                  r_in_range;
    logic [ADDR_W-1:0]     r_addr;
    logic [CLEAN_W-1:0]    r_clean;
    logic [TALLY16_W-1:0]  r_thr;
    logic [TALLY11_W-1:0]  r_ind_err;
    logic [TALLY11_W-1:0]  r_par_miss;
    logic [TALLY11_W-1:0]  r_ch_miss;
    logic [TALLY16_W-1:0]  r_ped_err;
    logic [TALLY11_W-1:0]  r_prob;
    logic [TALLY32_W-1:0]  r_rep;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_wb_vld;
    logic [ADDR_W-1:0]     r_wb_addr;
    t_result               r_stage;
    t_result               r_out;
    logic                  r_out_vld;

    logic [LOCUS_EXT_W-1:0] locus_ext;
    logic                   parent_missing;
    logic                   child_missing;
    logic                   bad;
    logic                   bmp_set;
    logic                   end_any;
    logic [TALLY11_W-1:0]   ind_new;
    logic [TALLY11_W-1:0]   par_new;
    logic [TALLY11_W-1:0]   ch_new;
    logic [TALLY16_W-1:0]   ped_new;
    logic [TALLY11_W-1:0]   prob_new;
    logic [TALLY32_W-1:0]   rep_new;
    t_result                stage_new;
    t_result                out_new;

    logic                   bmp_we;
    logic [ADDR_W-1:0]      bmp_waddr;
    logic [0:0]             bmp_wdata;
    logic                   bmp_re;
    logic [ADDR_W-1:0]      bmp_raddr;
    logic [0:0]             bmp_rdata;
    logic                   cnt_we;
    logic [ADDR_W-1:0]      cnt_waddr;
    logic [TALLY16_W-1:0]   cnt_wdata;
    logic                   cnt_re;
    logic [ADDR_W-1:0]      cnt_raddr;
    logic [TALLY16_W-1:0]   cnt_rdata;
    logic [TALLY16_W-1:0]   cnt_inc;

    assign locus_ext = LOCUS_EXT_W'(i_item.locus);

    assign parent_missing = (r_item.mother_gt == GT_MISSING) ||
                            (r_item.father_gt == GT_MISSING);
    assign child_missing  = (r_item.child_gt == GT_MISSING);
    assign bad = r_item.has_parents && !child_missing && !parent_missing &&
                 !trio_consistent(r_item.mother_gt, r_item.father_gt, r_item.child_gt);
    assign bmp_set = bad && r_in_range && !bmp_rdata[0];
    assign end_any = r_item.last_of_individual || r_item.last_of_pedigree;

    assign ind_new  = (bad && r_ind_err != '1) ? r_ind_err + 1'b1 : r_ind_err;
    assign par_new  = (r_item.has_parents && parent_missing && r_par_miss != '1) ?
                      r_par_miss + 1'b1 : r_par_miss;
    assign ch_new   = (r_item.has_parents && child_missing && r_ch_miss != '1) ?
                      r_ch_miss + 1'b1 : r_ch_miss;
    assign ped_new  = (bad && r_ped_err != '1) ? r_ped_err + 1'b1 : r_ped_err;
    assign prob_new = (bmp_set && r_prob != '1) ? r_prob + 1'b1 : r_prob;
    assign rep_new  = (bad && r_rep != '1) ? r_rep + 1'b1 : r_rep;

    always_comb begin
        stage_new          = '0;
        stage_new.mismatch = bad;
        if (end_any) begin
            stage_new.individual_done      = 1'b1;
            stage_new.individual_errors    = ind_new;
            stage_new.missing_parent_count = par_new;
            stage_new.missing_child_count  = ch_new;
        end
        if (r_item.last_of_pedigree) begin
            stage_new.pedigree_done      = 1'b1;
            stage_new.pedigree_errors    = ped_new;
            stage_new.problem_loci_count = prob_new;
            stage_new.strip_loci         = (r_clean > CLEAN_STRIP) && (prob_new != '0);
            stage_new.purge_pedigree     = (r_clean == CLEAN_PURGE) && (r_thr != '0) &&
                                           (ped_new > r_thr);
        end
        stage_new.report_errors = rep_new;
    end

    always_comb begin
        out_new                  = r_stage;
        out_new.locus_flag_count = r_in_range ? cnt_rdata : '0;
    end

    assign cnt_inc = (cnt_rdata != '1) ? cnt_rdata + 1'b1 : cnt_rdata;

    always_comb begin
        bmp_we    = i_cmd.sweep_bmp || (i_cmd.update && bmp_set) || r_wb_vld;
        bmp_waddr = i_cmd.sweep_bmp ? r_idx : (i_cmd.update ? r_addr : r_wb_addr);
        bmp_wdata = i_cmd.update;
        bmp_re    = i_cmd.chk_rd || i_cmd.walk_rd;
        bmp_raddr = i_cmd.walk_rd ? r_idx : r_addr;
        cnt_we    = i_cmd.sweep_cnt || (r_wb_vld && bmp_rdata[0]);
        cnt_waddr = i_cmd.sweep_cnt ? r_idx : r_wb_addr;
        cnt_wdata = i_cmd.sweep_cnt ? '0 : cnt_inc;
        cnt_re    = i_cmd.walk_rd || i_cmd.look_rd;
        cnt_raddr = i_cmd.walk_rd ? r_idx : r_addr;
    end

    mec_ram #(
        .WIDTH  (1),
        .DEPTH  (NUM_LOCI),
        .ADDR_W (ADDR_W)
    ) u_bmp_ram (
        .i_clk   (i_clk),
        .i_we    (bmp_we),
        .i_waddr (bmp_waddr),
        .i_wdata (bmp_wdata),
        .i_re    (bmp_re),
        .i_raddr (bmp_raddr),
        .o_rdata (bmp_rdata)
    );

    mec_ram #(
        .WIDTH  (TALLY16_W),
        .DEPTH  (NUM_LOCI),
        .ADDR_W (ADDR_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clean    <= CLEAN_RESET;
            r_thr      <= '0;
            r_ind_err  <= '0;
            r_par_miss <= '0;
            r_ch_miss  <= '0;
            r_ped_err  <= '0;
            r_prob     <= '0;
            r_rep      <= '0;
            r_idx      <= '0;
            r_wb_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CLEAN_LEVEL: r_clean <= i_cfg_data[CLEAN_W-1:0];
                    CFG_PURGE_THR:   r_thr   <= i_cfg_data[TALLY16_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_item && i_item.first_of_report) begin
                r_rep <= '0;
            end
            if (i_cmd.update) begin
                r_rep <= rep_new;
                if (end_any) begin
                    r_ind_err  <= '0;
                    r_par_miss <= '0;
                    r_ch_miss  <= '0;
                end else begin
                    r_ind_err  <= ind_new;
                    r_par_miss <= par_new;
                    r_ch_miss  <= ch_new;
                end
                if (r_item.last_of_pedigree) begin
                    r_ped_err <= '0;
                    r_prob    <= '0;
                end else begin
                    r_ped_err <= ped_new;
                    r_prob    <= prob_new;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            end
            r_wb_vld <= i_cmd.walk_rd;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item     <= i_item;
            r_in_range <= locus_ext < LOCI_EXT;
            r_addr     <= locus_ext[ADDR_W-1:0];
        end
        r_wb_addr <= r_idx;
        if (i_cmd.update) begin
            r_stage <= stage_new;
        end
        if (i_cmd.out_load) begin
            r_out <= out_new;
        end
    end

    assign o_sts.idx_last = (r_idx == IDX_LAST);
    assign o_sts.walk_req = r_item.last_of_pedigree && (prob_new != '0);
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_result       = r_out;
endmodule

// ===== rtl/mendelian_error_checker_top.sv =====
// Top level: Mendelian inconsistency checker for biallelic genotype trios.
//
//   channel    dir   handshake      payload
//   i_item     in    valid/ready    locus, trio genotypes, boundary flags
//   o_result   out   valid/ready    mismatch, tallies, strip/purge decisions
//   i_cfg      in    valid/ready    register index, write data (ready always high)
//
// A plain request passes the check, update, lookup and result states before the next one is taken.
// A request with first_of_report first clears the locus counter RAM.
// A pedigree end with any problem locus adds a bitmap walk,
// one bitmap and counter RAM entry per cycle.
// After reset both RAMs are cleared with i_item.ready low.
// The result register holds a result while o_result stalls; the next request is taken meanwhile.
module mendelian_error_checker_top #(
    parameter int NUM_LOCI = mec_pkg::DEF_NUM_LOCI
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mec_item_if.sink     i_item,
    mec_result_if.source o_result,
    mec_cfg_if.sink      i_cfg
);
    import mec_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_item   item;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    assign item.locus              = i_item.locus;
    assign item.mother_gt          = i_item.mother_gt;
    assign item.father_gt          = i_item.father_gt;
    assign item.child_gt           = i_item.child_gt;
    assign item.has_parents        = i_item.has_parents;
    assign item.last_of_individual = i_item.last_of_individual;
    assign item.last_of_pedigree   = i_item.last_of_pedigree;
    assign item.first_of_report    = i_item.first_of_report;

    mec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_first (i_item.first_of_report),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mec_dp #(
        .NUM_LOCI (NUM_LOCI)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid                = out_valid;
    assign o_result.mismatch             = result.mismatch;
    assign o_result.locus_flag_count     = result.locus_flag_count;
    assign o_result.individual_done      = result.individual_done;
    assign o_result.individual_errors    = result.individual_errors;
    assign o_result.missing_parent_count = result.missing_parent_count;
    assign o_result.missing_child_count  = result.missing_child_count;
    assign o_result.pedigree_done        = result.pedigree_done;
    assign o_result.pedigree_errors      = result.pedigree_errors;
    assign o_result.problem_loci_count   = result.problem_loci_count;
    assign o_result.strip_loci           = result.strip_loci;
    assign o_result.purge_pedigree       = result.purge_pedigree;
    assign o_result.report_errors        = result.report_errors;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("request accepted while previous request still in progress");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten before it was taken");

    a_ped_closes_ind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.pedigree_done) |-> o_result.individual_done)
        else $error("pedigree end did not close the individual");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_item.ready)
        else $error("request taken before memory clear finished");
endmodule

// ===== tb/mendelian_error_checker_top_tb.sv =====
// Testbench for the Mendelian error checker: directed trios and random pedigrees checked against a trio predictor.
module mendelian_error_checker_top_tb;
    import mec_pkg::*;

    localparam int NUM_LOCI    = DEF_NUM_LOCI;
    localparam int QUIET_LIMIT = 20 * NUM_LOCI;
    localparam int SETTLE      = NUM_LOCI + 32;

    localparam logic [GT_W-1:0] HOM_LO = 2'd1;
    localparam logic [GT_W-1:0] HOM_HI = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mec_item_if   item_if ();
    mec_result_if res_if ();
    mec_cfg_if    cfg_if ();

    mendelian_error_checker_top #(
        .NUM_LOCI (NUM_LOCI)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    bit [TALLY16_W-1:0] flag_cnt [NUM_LOCI];
    bit                 problem_map [NUM_LOCI];
    bit [TALLY11_W-1:0] ind_err, par_miss, kid_miss, prob_cnt;
    bit [TALLY16_W-1:0] ped_err;
    bit [TALLY32_W-1:0] rep_err;
    bit [CLEAN_W-1:0]   cfg_level = CLEAN_RESET;
    bit [TALLY16_W-1:0] cfg_thr = '0;

    t_result pending_results [$];
    t_result got_res, want_res;

    int errors, items_sent, results_seen, bad_seen, ped_seen, strip_seen, purge_seen;
    int quiet_cycles, rx_stall_left, rx_hold_req;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    function automatic bit mendel_ok(logic [GT_W-1:0] m, logic [GT_W-1:0] f,
                                     logic [GT_W-1:0] c);
        if (m == f) return (m == GT_HET) || (c == m);
        if (m == GT_HET || f == GT_HET) return (c == m) || (c == f);
        return c == GT_HET;
    endfunction

    function automatic t_result trio_outcome(t_item it);
        t_result r;
        bit      bad;
        bit      in_range;
        r        = '0;
        bad      = 1'b0;
        in_range = (int'(it.locus) < NUM_LOCI);
        if (it.first_of_report) begin
            foreach (flag_cnt[i]) flag_cnt[i] = '0;
            rep_err = '0;
        end
        if (it.has_parents) begin
            if (it.child_gt == GT_MISSING && kid_miss != '1) kid_miss++;
            if (it.mother_gt == GT_MISSING || it.father_gt == GT_MISSING) begin
                if (par_miss != '1) par_miss++;
            end else if (it.child_gt != GT_MISSING) begin
                bad = !mendel_ok(it.mother_gt, it.father_gt, it.child_gt);
            end
        end
        if (bad) begin
            if (in_range && !problem_map[it.locus]) begin
                problem_map[it.locus] = 1'b1;
                if (prob_cnt != '1) prob_cnt++;
            end
            if (ind_err != '1) ind_err++;
            if (ped_err != '1) ped_err++;
            if (rep_err != '1) rep_err++;
        end
        r.mismatch = bad;
        if (it.last_of_individual || it.last_of_pedigree) begin
            r.individual_done      = 1'b1;
            r.individual_errors    = ind_err;
            r.missing_parent_count = par_miss;
            r.missing_child_count  = kid_miss;
            ind_err  = '0;
            par_miss = '0;
            kid_miss = '0;
        end
        if (it.last_of_pedigree) begin
            foreach (problem_map[i]) begin
                if (problem_map[i] && flag_cnt[i] != '1) flag_cnt[i]++;
            end
            r.pedigree_done      = 1'b1;
            r.pedigree_errors    = ped_err;
            r.problem_loci_count = prob_cnt;
            r.strip_loci         = (cfg_level > CLEAN_STRIP) && (prob_cnt != 0);
            r.purge_pedigree     = (cfg_level == CLEAN_PURGE) && (cfg_thr != 0) &&
                                   (ped_err > cfg_thr);
            foreach (problem_map[i]) problem_map[i] = 1'b0;
            ped_err  = '0;
            prob_cnt = '0;
        end
        r.locus_flag_count = in_range ? flag_cnt[it.locus] : '0;
        r.report_errors    = rep_err;
        return r;
    endfunction

    function automatic t_item trio(logic [LOCUS_W-1:0] locus, logic [GT_W-1:0] m,
                                   logic [GT_W-1:0] f, logic [GT_W-1:0] c, bit par,
                                   bit end_ind, bit end_ped, bit first);
        t_item it;
        it.locus              = locus;
        it.mother_gt          = m;
        it.father_gt          = f;
        it.child_gt           = c;
        it.has_parents        = par;
        it.last_of_individual = end_ind;
        it.last_of_pedigree   = end_ped;
        it.first_of_report    = first;
        return it;
    endfunction

    function automatic t_item random_trio(logic [LOCUS_W-1:0] locus, int bad_pct);
        t_item it;
        bit    want_bad;
        it = '0;
        it.locus       = locus;
        it.has_parents = ($urandom_range(0, 99) >= 5);
        it.mother_gt   = ($urandom_range(0, 99) < 6) ? GT_MISSING : GT_W'($urandom_range(1, 3));
        it.father_gt   = ($urandom_range(0, 99) < 6) ? GT_MISSING : GT_W'($urandom_range(1, 3));
        it.child_gt    = ($urandom_range(0, 99) < 6) ? GT_MISSING : GT_W'($urandom_range(1, 3));
        want_bad       = ($urandom_range(0, 99) < bad_pct);
        if (it.mother_gt != GT_MISSING && it.father_gt != GT_MISSING &&
            it.child_gt != GT_MISSING) begin
            repeat (8) begin
                if (mendel_ok(it.mother_gt, it.father_gt, it.child_gt) != want_bad) break;
                it.child_gt = GT_W'($urandom_range(1, 3));
            end
        end
        return it;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Result side: random stalls and requested long hold-offs
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            res_if.ready  <= 1'b0;
        end else if (rx_hold_req != 0) begin
            rx_stall_left <= rx_hold_req - 1;
            rx_hold_req   <= 0;
            res_if.ready  <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_stall_left <= $urandom_range(0, 12);
            res_if.ready  <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            got_res.mismatch             = res_if.mismatch;
            got_res.locus_flag_count     = res_if.locus_flag_count;
            got_res.individual_done      = res_if.individual_done;
            got_res.individual_errors    = res_if.individual_errors;
            got_res.missing_parent_count = res_if.missing_parent_count;
            got_res.missing_child_count  = res_if.missing_child_count;
            got_res.pedigree_done        = res_if.pedigree_done;
            got_res.pedigree_errors      = res_if.pedigree_errors;
            got_res.problem_loci_count   = res_if.problem_loci_count;
            got_res.strip_loci           = res_if.strip_loci;
            got_res.purge_pedigree       = res_if.purge_pedigree;
            got_res.report_errors        = res_if.report_errors;
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result arrived with no request outstanding");
            end else begin
                want_res = pending_results.pop_front();
                check_field("mismatch", want_res.mismatch, got_res.mismatch);
                check_field("locus_flag_count", want_res.locus_flag_count,
                            got_res.locus_flag_count);
                check_field("individual_done", want_res.individual_done,
                            got_res.individual_done);
                check_field("individual_errors", want_res.individual_errors,
                            got_res.individual_errors);
                check_field("missing_parent_count", want_res.missing_parent_count,
                            got_res.missing_parent_count);
                check_field("missing_child_count", want_res.missing_child_count,
                            got_res.missing_child_count);
                check_field("pedigree_done", want_res.pedigree_done, got_res.pedigree_done);
                check_field("pedigree_errors", want_res.pedigree_errors,
                            got_res.pedigree_errors);
                check_field("problem_loci_count", want_res.problem_loci_count,
                            got_res.problem_loci_count);
                check_field("strip_loci", want_res.strip_loci, got_res.strip_loci);
                check_field("purge_pedigree", want_res.purge_pedigree, got_res.purge_pedigree);
                check_field("report_errors", want_res.report_errors, got_res.report_errors);
                bad_seen   += want_res.mismatch;
                ped_seen   += want_res.pedigree_done;
                strip_seen += want_res.strip_loci;
                purge_seen += want_res.purge_pedigree;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(t_item it);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        item_if.valid              <= 1'b1;
        item_if.locus              <= it.locus;
        item_if.mother_gt          <= it.mother_gt;
        item_if.father_gt          <= it.father_gt;
        item_if.child_gt           <= it.child_gt;
        item_if.has_parents        <= it.has_parents;
        item_if.last_of_individual <= it.last_of_individual;
        item_if.last_of_pedigree   <= it.last_of_pedigree;
        item_if.first_of_report    <= it.first_of_report;
        do @(posedge i_clk); while (!item_if.ready);
        pending_results.push_back(trio_outcome(it));
        items_sent++;
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(bit [CLEAN_W-1:0] level, bit [TALLY16_W-1:0] thr);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_CLEAN_LEVEL;
        cfg_if.data  <= CFG_DATA_W'(level);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_level = level;
        cfg_if.index <= CFG_PURGE_THR;
        cfg_if.data  <= thr;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_thr = thr;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_pedigree(int bad_pct);
        int                 n_ind, n_loc;
        logic [LOCUS_W-1:0] base;
        t_item              it;
        n_ind = $urandom_range(1, 4);
        n_loc = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        base  = LOCUS_W'($urandom);
        for (int ind = 0; ind < n_ind; ind++) begin
            for (int l = 0; l < n_loc; l++) begin
                it = random_trio(base + LOCUS_W'(l), bad_pct);
                it.last_of_individual = (l == n_loc - 1);
                it.last_of_pedigree   = (ind == n_ind - 1) && (l == n_loc - 1);
                if (it.last_of_pedigree) it.last_of_individual = $urandom_range(0, 1);
                it.first_of_report = (ind == 0) && (l == 0) && ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 99) < 4) begin
                    it = t_item'($bits(t_item)'($urandom));
                    it.first_of_report = ($urandom_range(0, 9) == 0);
                end
                send_item(it);
            end
        end
    endtask

    function automatic int pick_bad_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    task automatic test_directed();
        send_item(trio(10'd0,    HOM_LO,     HOM_LO,     HOM_LO,     1, 0, 0, 1));
        send_item(trio(10'd1023, HOM_LO,     HOM_LO,     HOM_HI,     1, 0, 0, 0));
        send_item(trio(10'd1023, HOM_HI,     HOM_HI,     HOM_LO,     1, 0, 0, 0));
        send_item(trio(10'd2,    GT_HET,     GT_HET,     HOM_LO,     1, 0, 0, 0));
        send_item(trio(10'd3,    HOM_LO,     GT_HET,     HOM_HI,     1, 0, 0, 0));
        send_item(trio(10'd4,    HOM_HI,     GT_HET,     GT_HET,     1, 0, 0, 0));
        send_item(trio(10'd5,    HOM_LO,     HOM_HI,     HOM_LO,     1, 0, 0, 0));
        send_item(trio(10'd6,    HOM_HI,     HOM_LO,     GT_HET,     1, 0, 0, 0));
        send_item(trio(10'd7,    HOM_LO,     HOM_LO,     HOM_HI,     0, 0, 0, 0));
        send_item(trio(10'd8,    HOM_LO,     HOM_HI,     GT_MISSING, 1, 0, 0, 0));
        send_item(trio(10'd9,    GT_MISSING, GT_HET,     GT_MISSING, 1, 0, 0, 0));
        send_item(trio(10'd10,   GT_HET,     GT_MISSING, GT_HET,     1, 1, 0, 0));
        send_item(trio(10'd5,    HOM_LO,     HOM_LO,     GT_HET,     1, 0, 0, 0));
        send_item(trio(10'd11,   GT_MISSING, GT_MISSING, GT_MISSING, 1, 0, 0, 0));
        send_item(trio(10'd5,    GT_HET,     GT_HET,     GT_HET,     1, 0, 1, 0));
        send_item(trio(10'd12,   HOM_HI,     HOM_HI,     HOM_HI,     1, 1, 1, 0));
        send_item(trio(10'd1023, HOM_HI,     HOM_LO,     HOM_HI,     1, 1, 1, 0));
        send_item(trio(10'd1023, HOM_LO,     HOM_LO,     HOM_LO,     1, 1, 1, 1));
    endtask

    task automatic test_clean_levels();
        bit [CLEAN_W-1:0]   levels [6] = '{CLEAN_PURGE, 2'd2, 2'd0, CLEAN_PURGE,
                                           CLEAN_STRIP, CLEAN_PURGE};
        bit [TALLY16_W-1:0] thrs [6]   = '{16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd2, 16'hFFFF};
        for (int s = 0; s < 6; s++) begin
            write_config(levels[s], thrs[s]);
            repeat (5) send_pedigree(30);
        end
    endtask

    task automatic test_random_traffic(int n_items);
        int                 stop_at, next_cfg;
        bit [TALLY16_W-1:0] thr;
        stop_at  = items_sent + n_items;
        next_cfg = items_sent + 150;
        while (items_sent < stop_at) begin
            if (items_sent >= next_cfg) begin
                case ($urandom_range(0, 3))
                    0:       thr = '0;
                    1:       thr = TALLY16_W'($urandom_range(1, 4));
                    2:       thr = '1;
                    default: thr = TALLY16_W'($urandom);
                endcase
                write_config(CLEAN_W'($urandom_range(0, 3)), thr);
                next_cfg = items_sent + 150;
            end
            send_pedigree(pick_bad_pct());
        end
    endtask

    task automatic test_output_backpressure();
        write_config(CLEAN_PURGE, 16'd2);
        rx_hold_req <= 400;
        repeat (4) send_pedigree(40);
    endtask

    task automatic test_input_drain();
        repeat (2) send_pedigree(pick_bad_pct());
        drain_results();
        repeat (2) send_pedigree(pick_bad_pct());
    endtask

    task automatic test_streaming(int n_items);
        int stop_at;
        stop_at    = items_sent + n_items;
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        while (items_sent < stop_at) send_pedigree(pick_bad_pct());
    endtask

    initial begin
        i_rst_n                    = 1'b0;
        item_if.valid              = 1'b0;
        item_if.locus              = '0;
        item_if.mother_gt          = '0;
        item_if.father_gt          = '0;
        item_if.child_gt           = '0;
        item_if.has_parents        = 1'b0;
        item_if.last_of_individual = 1'b0;
        item_if.last_of_pedigree   = 1'b0;
        item_if.first_of_report    = 1'b0;
        cfg_if.valid               = 1'b0;
        cfg_if.index               = '0;
        cfg_if.data                = '0;
        res_if.ready               = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_clean_levels();
        test_random_traffic(750);
        test_output_backpressure();
        test_input_drain();
        test_streaming(120);

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Checked %0d results from %0d requests across %0d pedigree ends",
                 results_seen, items_sent, ped_seen);
        $display("Saw %0d inconsistent trios, %0d strip and %0d purge decisions",
                 bad_seen, strip_seen, purge_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
